// ----- rtl/bbr_pkg.sv -----
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared types and constants of the RGB box blur block.
// ----------------------------------------------------------------------------
`default_nettype none

package bbr_pkg;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_W     = 8;
    localparam int RGB_W     = 3 * PIX_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    // operation codes
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic push;
        logic cfg_write;
        logic scan_init;
        logic scan_read;
        logic div_start;
        logic div_step;
        logic load_out;
    } bbr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic result_ready;
        logic scan_last;
        logic div_busy;
        logic out_free;
    } bbr_stat_t;

endpackage

`default_nettype wire

// ----- rtl/bbr_ram.sv -----
// ----------------------------------------------------------------------------
// bbr_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bbr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        rd_data <= mem[addr];
    end

endmodule

`default_nettype wire

// ----- rtl/bbr_datapath.sv -----
// ----------------------------------------------------------------------------
// bbr_datapath
// Position counters, line store, window accumulation, dividers and
// output register of the box blur.
// ----------------------------------------------------------------------------
`default_nettype none

module bbr_datapath #(
    parameter int RADIUS     = 6,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bbr_pkg::bbr_cmd_t             cmd,
    output bbr_pkg::bbr_stat_t                 stat,
    input  wire logic [bbr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bbr_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          s_operation,
    input  wire logic [bbr_pkg::PIX_W-1:0]     s_in_red,
    input  wire logic [bbr_pkg::PIX_W-1:0]     s_in_green,
    input  wire logic [bbr_pkg::PIX_W-1:0]     s_in_blue,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [bbr_pkg::PIX_W-1:0]     m_out_red,
    output logic      [bbr_pkg::PIX_W-1:0]     m_out_green,
    output logic      [bbr_pkg::PIX_W-1:0]     m_out_blue,
    output logic                               m_frame_end
);
    import bbr_pkg::*;

    localparam int LINES  = 2 * RADIUS + 2;
    localparam int WIN    = 2 * RADIUS + 1;
    localparam int SLOT_W = $clog2(LINES);
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int H_W    = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int DEPTH  = LINES * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(WIN * WIN + 1);
    localparam int SUM_W  = $clog2(WIN * WIN * 255 + 1);
    localparam int NUM_W  = SUM_W + 2;
    localparam int DEN_W  = CNT_W + 1;
    localparam int DC_W   = $clog2(NUM_W + 1);

    // configuration
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [W_W-1:0]   w_eff;
    logic [H_W-1:0]   h_eff;

    // positions
    logic [H_W-1:0]    irow_reg, orow_reg, srow_reg;
    logic [COL_W-1:0]  icol_reg, ocol_reg, scol_reg;
    logic [SLOT_W-1:0] islot_reg, oslot_reg, sslot_reg;
    logic [H_W-1:0]    rlo, rhi;
    logic [COL_W-1:0]  clo, chi;
    logic [SLOT_W-1:0] slot_init, slot_back;
    logic              last_col, frame_done, push_en;

    // accumulation and division
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  acc_reg [3];
    logic [NUM_W-1:0]  num_reg [3];
    logic [DEN_W-1:0]  rem_reg [3];
    logic [DEN_W-1:0]  den_reg;
    logic [DC_W-1:0]   dcnt_reg;
    logic              rd_pend_reg;
    logic [RGB_W-1:0]  rd_data;
    logic [ADDR_W-1:0] ram_addr;
    logic [PIX_W-1:0]  rd_pix [3];

    // output register
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pix_reg [3];
    logic             out_end_reg;

    // clamp sizes to 1..MAX
    always_comb begin
        if (width_reg == '0) begin
            w_eff = W_W'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = W_W'(MAX_WIDTH);
        end else begin
            w_eff = W_W'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = H_W'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h_eff = H_W'(MAX_HEIGHT);
        end else begin
            h_eff = H_W'(height_reg);
        end
    end

    // window bounds of the current output pixel
    always_comb begin
        rlo = (32'(orow_reg) >= RADIUS) ? H_W'(32'(orow_reg) - RADIUS) : '0;
        rhi = (32'(orow_reg) + RADIUS > 32'(h_eff) - 1)
            ? H_W'(32'(h_eff) - 1) : H_W'(32'(orow_reg) + RADIUS);
        clo = (32'(ocol_reg) >= RADIUS) ? COL_W'(32'(ocol_reg) - RADIUS) : '0;
        chi = (32'(ocol_reg) + RADIUS > 32'(w_eff) - 1)
            ? COL_W'(32'(w_eff) - 1) : COL_W'(32'(ocol_reg) + RADIUS);
        slot_back = SLOT_W'(orow_reg - rlo);
        slot_init = (oslot_reg >= slot_back) ? SLOT_W'(oslot_reg - slot_back)
                  : SLOT_W'(32'(oslot_reg) + LINES - 32'(slot_back));
    end

    // status
    assign last_col   = 32'(ocol_reg) == 32'(w_eff) - 1;
    assign frame_done = last_col && (32'(orow_reg) == 32'(h_eff) - 1);
    assign push_en    = cmd.push && (s_operation == OP_PUSH) && (irow_reg < h_eff);

    always_comb begin
        stat.result_ready = (irow_reg > rhi) || ((irow_reg == rhi) && (icol_reg > chi));
        stat.scan_last    = (srow_reg == rhi) && (scol_reg == chi);
        stat.div_busy     = dcnt_reg != '0;
        stat.out_free     = !out_valid_reg || m_ready;
    end

    // line store
    assign ram_addr = push_en
        ? ADDR_W'(ADDR_W'(islot_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(icol_reg))
        : ADDR_W'(ADDR_W'(sslot_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(scol_reg));

    bbr_ram #(.WIDTH(RGB_W), .DEPTH(DEPTH)) u_line_store (
        .aclk    (aclk),
        .wr_en   (push_en),
        .addr    (ram_addr),
        .wr_data ({s_in_red, s_in_green, s_in_blue}),
        .rd_data (rd_data)
    );

    assign rd_pix[0] = rd_data[3*PIX_W-1:2*PIX_W];
    assign rd_pix[1] = rd_data[2*PIX_W-1:PIX_W];
    assign rd_pix[2] = rd_data[PIX_W-1:0];

    // configuration and position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            irow_reg   <= '0;
            icol_reg   <= '0;
            islot_reg  <= '0;
            orow_reg   <= '0;
            ocol_reg   <= '0;
            oslot_reg  <= '0;
        end else if (cmd.cfg_write) begin
            if (cfg_index == REG_WIDTH) begin
                width_reg <= cfg_data;
            end
            if (cfg_index == REG_HEIGHT) begin
                height_reg <= cfg_data;
            end
            if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT) begin
                irow_reg  <= '0;
                icol_reg  <= '0;
                islot_reg <= '0;
                orow_reg  <= '0;
                ocol_reg  <= '0;
                oslot_reg <= '0;
            end
        end else if (cmd.load_out && frame_done) begin
            irow_reg  <= '0;
            icol_reg  <= '0;
            islot_reg <= '0;
            orow_reg  <= '0;
            ocol_reg  <= '0;
            oslot_reg <= '0;
        end else begin
            if (push_en) begin
                if (32'(icol_reg) == 32'(w_eff) - 1) begin
                    icol_reg  <= '0;
                    irow_reg  <= irow_reg + 1'b1;
                    islot_reg <= (32'(islot_reg) == LINES - 1) ? '0 : islot_reg + 1'b1;
                end else begin
                    icol_reg <= icol_reg + 1'b1;
                end
            end
            if (cmd.load_out) begin
                if (last_col) begin
                    ocol_reg  <= '0;
                    orow_reg  <= orow_reg + 1'b1;
                    oslot_reg <= (32'(oslot_reg) == LINES - 1) ? '0 : oslot_reg + 1'b1;
                end else begin
                    ocol_reg <= ocol_reg + 1'b1;
                end
            end
        end
    end

    // window scan counters
    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            srow_reg  <= rlo;
            scol_reg  <= clo;
            sslot_reg <= slot_init;
            count_reg <= CNT_W'((32'(rhi) - 32'(rlo) + 1) * (32'(chi) - 32'(clo) + 1));
        end else if (cmd.scan_read) begin
            if (scol_reg == chi) begin
                scol_reg  <= clo;
                srow_reg  <= srow_reg + 1'b1;
                sslot_reg <= (32'(sslot_reg) == LINES - 1) ? '0 : sslot_reg + 1'b1;
            end else begin
                scol_reg <= scol_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.scan_read;
        end
    end

    // per-channel accumulate and restoring divide
    for (genvar k = 0; k < 3; k++) begin : g_chan
        logic [DEN_W:0] trial;
        assign trial = {rem_reg[k], num_reg[k][NUM_W-1]};

        always_ff @(posedge aclk) begin
            if (cmd.scan_init) begin
                acc_reg[k] <= '0;
            end else if (rd_pend_reg) begin
                acc_reg[k] <= acc_reg[k] + SUM_W'(rd_pix[k]);
            end
            if (cmd.div_start) begin
                num_reg[k] <= NUM_W'({acc_reg[k], 1'b0}) + NUM_W'(count_reg);
                rem_reg[k] <= '0;
            end else if (cmd.div_step) begin
                if (trial >= {1'b0, den_reg}) begin
                    rem_reg[k] <= DEN_W'(trial - {1'b0, den_reg});
                    num_reg[k] <= {num_reg[k][NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg[k] <= DEN_W'(trial);
                    num_reg[k] <= {num_reg[k][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            den_reg <= {count_reg, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.div_start) begin
            dcnt_reg <= DC_W'(NUM_W);
        end else if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_pix_reg[0] <= num_reg[0][PIX_W-1:0];
            out_pix_reg[1] <= num_reg[1][PIX_W-1:0];
            out_pix_reg[2] <= num_reg[2][PIX_W-1:0];
            out_end_reg    <= frame_done;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_out_red   = out_pix_reg[0];
    assign m_out_green = out_pix_reg[1];
    assign m_out_blue  = out_pix_reg[2];
    assign m_frame_end = out_end_reg;

endmodule

`default_nettype wire

// ----- rtl/bbr_ctrl.sv -----
// ----------------------------------------------------------------------------
// bbr_ctrl
// Sequencer of the box blur: accept, check, window scan, divide, output.
// ----------------------------------------------------------------------------
`default_nettype none

module bbr_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    output bbr_pkg::bbr_cmd_t       cmd,
    input  wire bbr_pkg::bbr_stat_t stat
);
    import bbr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DIVI  = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;

    assign cfg_ready = state_reg == ST_IDLE;
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    cmd.cfg_write = 1'b1;
                end else if (s_valid) begin
                    cmd.push   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.result_ready) begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                cmd.scan_read = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DIVI;
            ST_DIVI: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_busy) begin
                    cmd.div_step = 1'b1;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/box_blur_rgb_unit.sv -----
// ----------------------------------------------------------------------------
// box_blur_rgb_unit
// 13x13 mean filter over a raster-order RGB pixel stream.
// ----------------------------------------------------------------------------
// Input channel s_*: one item per pixel (operation = push) or a flush step
// (operation = flush, pixel ignored). Each item yields zero or one result on
// m_*, the mean of the pixel neighborhood that has fully arrived, with
// frame_end on the last pixel of the frame. Sizes are set through the cfg_*
// write port (index 0 width, 1 height); a write to either restarts the frame.
// An item that yields no result is only accepted and checked. An item that
// yields a result then goes through window scan, drain, divider start, divide
// and output: the window is read from the single-port line store one pixel
// per cycle, then a restoring divider takes one quotient bit per cycle (18
// bits at radius 6).
// Reset (synchronous, aresetn low) sets width 640, height 480 and restarts
// the frame; the line store is not cleared and needs no sweep. A result waits
// in the output register while m_ready is low; the next item is accepted
// meanwhile and its result waits in the sequencer until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_rgb_unit #(
    parameter int RADIUS     = 6,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_operation,
    input  wire logic [bbr_pkg::PIX_W-1:0]     s_in_red,
    input  wire logic [bbr_pkg::PIX_W-1:0]     s_in_green,
    input  wire logic [bbr_pkg::PIX_W-1:0]     s_in_blue,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [bbr_pkg::PIX_W-1:0]     m_out_red,
    output logic      [bbr_pkg::PIX_W-1:0]     m_out_green,
    output logic      [bbr_pkg::PIX_W-1:0]     m_out_blue,
    output logic                               m_frame_end,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bbr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bbr_pkg::CFG_W-1:0]     cfg_data
);
    import bbr_pkg::*;

    bbr_cmd_t  cmd;
    bbr_stat_t stat;

    bbr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    bbr_datapath #(
        .RADIUS     (RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_operation (s_operation),
        .s_in_red    (s_in_red),
        .s_in_green  (s_in_green),
        .s_in_blue   (s_in_blue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_frame_end (m_frame_end)
    );

endmodule

`default_nettype wire
